// ===== hw/rtl/aggregation_slot_manager_assert.svh =====
// Assertion macros shared by the aggregation slot manager.
`ifndef AGGREGATION_SLOT_MANAGER_ASSERT_SVH
`define AGGREGATION_SLOT_MANAGER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/asm_pkg.sv =====
package asm_pkg;

  // Result actions.
  localparam logic [1:0] ACT_FORWARD = 2'd0;
  localparam logic [1:0] ACT_ABSORB  = 2'd1;
  localparam logic [1:0] ACT_EMIT    = 2'd2;

  // Register map: word index taken from paddr[2].
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_FANIN = 1'b0;
  localparam logic REG_ECN   = 1'b1;

  localparam logic [7:0] FANIN_RESET = 8'd2;
  localparam logic [4:0] ECN_RESET   = 5'd16;

  // One packet descriptor held in the input register.
  typedef struct packed {
    logic        is_data;
    logic [7:0]  job_id;
    logic [7:0]  seq_num;
    logic [15:0] packet_ref;
  } item_t;

  // Lookup request toward the slot table.
  typedef struct packed {
    logic       is_data;
    logic [7:0] job_id;
    logic [7:0] seq_num;
  } lookup_req_t;

  // Decision returned by the slot table.
  typedef struct packed {
    logic [1:0] action;
    logic       ecn_mark;
  } verdict_t;

endpackage

// ===== hw/rtl/asm_cfg_regs.sv =====
module asm_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [asm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [7:0]                fanin_degree,
  output logic [4:0]                ecn_threshold
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      fanin_degree  <= asm_pkg::FANIN_RESET;
      ecn_threshold <= asm_pkg::ECN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        asm_pkg::REG_FANIN: fanin_degree  <= pwdata[7:0];
        asm_pkg::REG_ECN:   ecn_threshold <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read data is selected combinationally.
  always_comb begin
    unique case (paddr[2])
      asm_pkg::REG_FANIN: prdata = {24'd0, fanin_degree};
      asm_pkg::REG_ECN:   prdata = {27'd0, ecn_threshold};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/asm_slot_table.sv =====
module asm_slot_table #(
  parameter int NUM_SLOTS = 16,
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  asm_pkg::lookup_req_t req,
  input  logic [7:0]           fanin_degree,
  input  logic [4:0]           ecn_threshold,
  output asm_pkg::verdict_t    verdict,
  output logic [SW-1:0]        slot
);

  localparam int BW = $clog2(NUM_SLOTS + 1);
  localparam int CW = (BW > 5) ? BW : 5;

  logic [7:0]    slot_job   [NUM_SLOTS];
  logic [7:0]    slot_seq   [NUM_SLOTS];
  logic [7:0]    slot_count [NUM_SLOTS];
  logic [BW-1:0] busy;

  logic [NUM_SLOTS-1:0] hit;
  logic [NUM_SLOTS-1:0] free;
  logic [SW-1:0] match_idx;
  logic [SW-1:0] free_idx;
  logic          claim;
  logic          found;
  logic [7:0]    cur_count;
  logic [7:0]    inc_count;
  logic          done;
  logic          congested;

  // Compare every slot against the tag in parallel.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free[i] = (slot_count[i] == 8'd0);
      hit[i]  = !free[i] && (slot_job[i] == req.job_id) && (slot_seq[i] == req.seq_num);
    end
  end

  // Lowest-numbered matching slot and lowest-numbered free slot.
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match_idx = SW'(i);
      end
      if (free[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  // Pick the slot, bump its count and decide the action.
  always_comb begin
    claim     = (hit == '0);
    found     = req.is_data && ((hit != '0) || (free != '0));
    slot      = claim ? free_idx : match_idx;
    cur_count = slot_count[slot];
    inc_count = (cur_count == 8'hFF) ? cur_count : cur_count + 8'd1;
    done      = (inc_count >= fanin_degree);
    congested = (CW'(busy) >= CW'(ecn_threshold));

    if (!found) begin
      verdict.action   = asm_pkg::ACT_FORWARD;
      verdict.ecn_mark = 1'b0;
    end else if (done) begin
      verdict.action   = asm_pkg::ACT_EMIT;
      verdict.ecn_mark = congested;
    end else begin
      verdict.action   = asm_pkg::ACT_ABSORB;
      verdict.ecn_mark = 1'b0;
    end
  end

  // Counts and the busy tally; a count of zero marks a free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_count[i] <= 8'd0;
      end
      busy <= '0;
    end else if (update && found) begin
      if (done) begin
        slot_count[slot] <= 8'd0;
        if (!claim) begin
          busy <= busy - BW'(1);
        end
      end else begin
        slot_count[slot] <= inc_count;
        if (claim) begin
          busy <= busy + BW'(1);
        end
      end
    end
  end

  // Tags are only read while the count is nonzero, so they need no reset.
  always_ff @(posedge clk) begin
    if (update && found && claim) begin
      slot_job[slot] <= req.job_id;
      slot_seq[slot] <= req.seq_num;
    end
  end

endmodule

// ===== hw/rtl/aggregation_slot_manager.sv =====
// Aggregation slot manager.
// Input channel (in_valid/in_ready) carries one packet descriptor per transfer:
// is_data, job_id, seq_num, packet_ref. Output channel (out_valid/out_ready)
// returns exactly one result per input: action, ecn_mark, packet_ref_out and
// slot_index, in input order.
// The descriptor is captured in an input register at the transfer edge; the slot
// table lookup and update then complete and load the result register, unless the
// result register is held by a stall. Throughput is one item per cycle while the
// receiver does not stall; it is set by the read-modify-write of the slot table,
// which each item finishes before the next one looks it up.
// When the receiver stalls, the result register holds its value, and one more
// descriptor may still be taken into the input register; after that in_ready
// drops until the result is taken.
// Synchronous reset frees all slots, clears the busy tally, empties both
// registers and restores fanin_degree to 2 and ecn_threshold to 16.
// Configuration goes through the APB port at byte addresses 0 and 4; the user must
// write it only while the block is idle, which the block itself does not enforce.
module aggregation_slot_manager #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       is_data,
  input  logic [7:0]                 job_id,
  input  logic [7:0]                 seq_num,
  input  logic [15:0]                packet_ref,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 action,
  output logic                       ecn_mark,
  output logic [15:0]                packet_ref_out,
  output logic [3:0]                 slot_index,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [asm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [7:0]           fanin_degree;
  logic [4:0]           ecn_threshold;
  logic                 s1_valid;
  asm_pkg::item_t       s1_item;
  logic                 advance;
  asm_pkg::lookup_req_t req;
  asm_pkg::verdict_t    verdict;
  logic [SW-1:0]        slot;
  logic [SW+3:0]        slot_ext;

  asm_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fanin_degree  (fanin_degree),
    .ecn_threshold (ecn_threshold)
  );

  // The input register drains into the result register unless that one is stuck.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{is_data: is_data, job_id: job_id, seq_num: seq_num,
                   packet_ref: packet_ref};
    end
  end

  assign req = '{is_data: s1_item.is_data, job_id: s1_item.job_id,
                 seq_num: s1_item.seq_num};

  asm_slot_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk           (clk),
    .rst           (rst),
    .update        (advance),
    .req           (req),
    .fanin_degree  (fanin_degree),
    .ecn_threshold (ecn_threshold),
    .verdict       (verdict),
    .slot          (slot)
  );

  assign slot_ext = {4'd0, slot};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action   <= verdict.action;
      ecn_mark <= verdict.ecn_mark;
      case (verdict.action)
        asm_pkg::ACT_ABSORB: begin
          packet_ref_out <= 16'd0;
          slot_index     <= slot_ext[3:0];
        end
        asm_pkg::ACT_EMIT: begin
          packet_ref_out <= s1_item.packet_ref;
          slot_index     <= slot_ext[3:0];
        end
        default: begin
          packet_ref_out <= s1_item.packet_ref;
          slot_index     <= 4'd0;
        end
      endcase
    end
  end

  `include "aggregation_slot_manager_assert.svh"

  `ASM_ASSERT_NOW(a_absorb_clean, clk, rst, out_valid && (action == asm_pkg::ACT_ABSORB), (packet_ref_out == 16'd0) && !ecn_mark, "absorbed result carries a handle or mark")
  `ASM_ASSERT_NOW(a_forward_clean, clk, rst, out_valid && (action == asm_pkg::ACT_FORWARD), (slot_index == 4'd0) && !ecn_mark, "forwarded result carries a slot or mark")
  `ASM_ASSERT_NOW(a_full_stall, clk, rst, s1_valid && out_valid && !out_ready, !in_ready, "input taken while both registers are held")
  `ASM_ASSERT_NEXT(a_advance_loads, clk, rst, advance, out_valid, "result register not loaded after advance")

endmodule

// ===== tb/asm_tb_pkg.sv =====
package asm_tb_pkg;

  import asm_pkg::*;

  localparam int SLOT_COUNT = 16;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [1:0]  action;
    logic        ecn_mark;
    logic [15:0] packet_ref_out;
    logic [3:0]  slot_index;
  } agg_result_t;

  // Mirror of the slot table and registers, plus the results still owed by the block.
  class aggregation_scoreboard;
    logic [7:0]  slot_job_mirror [SLOT_COUNT];
    logic [7:0]  slot_seq_mirror [SLOT_COUNT];
    logic [7:0]  slot_cnt_mirror [SLOT_COUNT];
    logic [7:0]  fanin;
    logic [4:0]  ecn_thr;
    agg_result_t due_results[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_job_mirror[i] = 8'd0;
        slot_seq_mirror[i] = 8'd0;
        slot_cnt_mirror[i] = 8'd0;
      end
      fanin   = FANIN_RESET;
      ecn_thr = ECN_RESET;
      errors  = 0;
    endfunction

    function void write_reg(logic reg_sel, logic [31:0] value);
      if (reg_sel == REG_FANIN) begin
        fanin = value[7:0];
      end else begin
        ecn_thr = value[4:0];
      end
    endfunction

    function void check_register(logic reg_sel, logic [31:0] got);
      logic [31:0] want;
      want = (reg_sel == REG_FANIN) ? {24'd0, fanin} : {27'd0, ecn_thr};
      if (got !== want) begin
        $error("prdata of register %0d: expected %0d, got %0d", reg_sel, want, got);
        errors++;
      end
    endfunction

    // Work out the result of one accepted descriptor and update the slot mirror.
    function void note_packet(item_t pkt);
      agg_result_t res;
      int          busy;
      int          hit;
      logic        mark;
      res.action         = ACT_FORWARD;
      res.ecn_mark       = 1'b0;
      res.packet_ref_out = pkt.packet_ref;
      res.slot_index     = 4'd0;
      if (pkt.is_data) begin
        busy = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_cnt_mirror[i] != 8'd0) busy++;
        end
        mark = (busy >= ecn_thr);
        hit = -1;
        // A busy slot of the same job and sequence wins over a free one.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (hit < 0 && slot_cnt_mirror[i] != 8'd0 && slot_job_mirror[i] == pkt.job_id &&
              slot_seq_mirror[i] == pkt.seq_num) begin
            hit = i;
          end
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (hit < 0 && slot_cnt_mirror[i] == 8'd0) begin
            hit = i;
            slot_job_mirror[i] = pkt.job_id;
            slot_seq_mirror[i] = pkt.seq_num;
          end
        end
        // With no slot to be had the packet simply passes through.
        if (hit >= 0) begin
          if (slot_cnt_mirror[hit] != 8'hff) slot_cnt_mirror[hit] = slot_cnt_mirror[hit] + 8'd1;
          res.slot_index = hit[3:0];
          if (slot_cnt_mirror[hit] >= fanin) begin
            slot_job_mirror[hit] = 8'd0;
            slot_seq_mirror[hit] = 8'd0;
            slot_cnt_mirror[hit] = 8'd0;
            res.action   = ACT_EMIT;
            res.ecn_mark = mark;
          end else begin
            res.action         = ACT_ABSORB;
            res.packet_ref_out = 16'd0;
          end
        end
      end
      due_results.insert(due_results.size(), res);
    endfunction

    // Compare one result from the block with the oldest one owed.
    function void check_result(agg_result_t got);
      agg_result_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with no result owed: action %0d, packet_ref_out %0d",
               got.action, got.packet_ref_out);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        errors++;
      end
      if (got.ecn_mark !== want.ecn_mark) begin
        $error("ecn_mark: expected %0d, got %0d", want.ecn_mark, got.ecn_mark);
        errors++;
      end
      if (got.packet_ref_out !== want.packet_ref_out) begin
        $error("packet_ref_out: expected %0d, got %0d", want.packet_ref_out,
               got.packet_ref_out);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
module tb_top;

  import asm_pkg::*;
  import asm_tb_pkg::*;

  localparam int KEY_COUNT     = 48;
  localparam int PHASE_COUNT   = 8;
  localparam int WATCHDOG_IDLE = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                is_data = 1'b0;
  logic [7:0]          job_id = 8'd0;
  logic [7:0]          seq_num = 8'd0;
  logic [15:0]         packet_ref = 16'd0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          action;
  logic                ecn_mark;
  logic [15:0]         packet_ref_out;
  logic [3:0]          slot_index;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = 32'd0;
  logic [31:0]         prdata;
  logic                pready;

  aggregation_scoreboard sb;

  // Job and sequence pairs that the traffic draws on, so that slots fill and complete.
  logic [7:0] key_job [KEY_COUNT];
  logic [7:0] key_seq [KEY_COUNT];

  // Settings of each phase: fan-in, threshold, keys in use, item count, share of noise.
  int phase_fanin [PHASE_COUNT] = '{2, 1, 4, 255, 3, 0, 8, 2};
  int phase_thr   [PHASE_COUNT] = '{16, 0, 8, 31, 4, 2, 12, 16};
  int phase_keys  [PHASE_COUNT] = '{20, 48, 12, 1, 16, 48, 24, 20};
  int phase_items [PHASE_COUNT] = '{110, 100, 130, 320, 120, 90, 130, 100};
  int phase_noise [PHASE_COUNT] = '{10, 10, 15, 5, 10, 10, 15, 10};

  int          burst_left = 0;
  logic [15:0] ready_mask = 16'hffff;
  logic [5:0]  ready_phase = 6'd0;
  int          idle_cycles;

  aggregation_slot_manager dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .is_data        (is_data),
    .job_id         (job_id),
    .seq_num        (seq_num),
    .packet_ref     (packet_ref),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .ecn_mark       (ecn_mark),
    .packet_ref_out (packet_ref_out),
    .slot_index     (slot_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver follows a random stall mask that is redrawn whenever ready_phase wraps to zero.
  always @(posedge clk) begin
    if (ready_phase == 6'd0) begin
      case ($urandom_range(0, 3))
        0: ready_mask = 16'hffff;
        1: ready_mask = 16'($urandom);
        2: ready_mask = 16'($urandom & $urandom);
        default: ready_mask = 16'($urandom | $urandom);
      endcase
    end
    out_ready <= ready_mask[ready_phase[3:0]];
    ready_phase = ready_phase + 6'd1;
  end

  // Every result transfer is checked against the oldest result owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result({action, ecn_mark, packet_ref_out, slot_index});
    end
  end

  // The run ends with a failure when nothing moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_IDLE) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic apb_write(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(reg_sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic reg_sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_register(reg_sel, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Present one descriptor, with a random gap at the end of each burst.
  task automatic issue_packet(input logic data, input logic [7:0] job, input logic [7:0] seq,
                              input logic [15:0] handle);
    item_t pkt;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    is_data    <= data;
    job_id     <= job;
    seq_num    <= seq;
    packet_ref <= handle;
    do @(posedge clk); while (!in_ready);
    pkt.is_data    = data;
    pkt.job_id     = job;
    pkt.seq_num    = seq;
    pkt.packet_ref = handle;
    sb.note_packet(pkt);
  endtask

  // Mostly packets of the phase's keys; the rest are non-data packets and stray keys.
  task automatic random_packet(input int keys, input int noise);
    int          pick;
    int          k;
    logic [15:0] handle;
    pick   = $urandom_range(0, 99);
    handle = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 19) == 0) handle = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    if (pick < noise / 2) begin
      issue_packet(1'b0, 8'($urandom), 8'($urandom), handle);
    end else begin
      k = (pick < noise) ? $urandom_range(0, KEY_COUNT - 1) : $urandom_range(0, keys - 1);
      issue_packet(1'b1, key_job[k], key_seq[k], handle);
    end
  endtask

  // Let every owed result arrive and the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < KEY_COUNT; i++) begin
      key_job[i] = 8'($urandom);
      key_seq[i] = 8'($urandom);
    end
    key_job[0] = 8'hff;
    key_seq[0] = 8'hff;
    key_job[1] = 8'h00;
    key_seq[1] = 8'h00;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read(REG_FANIN);
    apb_read(REG_ECN);

    // Non-data packets at the field extremes pass through.
    issue_packet(1'b0, 8'h00, 8'h00, 16'h0000);
    issue_packet(1'b0, 8'hff, 8'hff, 16'hffff);
    // One pair completes at the reset fan-in.
    issue_packet(1'b1, key_job[0], key_seq[0], 16'hffff);
    issue_packet(1'b1, key_job[0], key_seq[0], 16'h5a5a);
    // Fill every slot, then a new key finds the table full.
    for (int i = 1; i <= 16; i++) begin
      issue_packet(1'b1, key_job[i], key_seq[i], 16'($urandom_range(0, 65535)));
    end
    issue_packet(1'b1, key_job[17], key_seq[17], 16'($urandom_range(0, 65535)));
    // Completion with all slots busy carries the congestion mark.
    issue_packet(1'b1, key_job[3], key_seq[3], 16'($urandom_range(0, 65535)));
    // A non-data packet that matches a busy slot leaves it alone.
    issue_packet(1'b0, key_job[5], key_seq[5], 16'($urandom_range(0, 65535)));
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p > 0) begin
        apb_write(REG_FANIN, phase_fanin[p]);
        apb_write(REG_ECN, phase_thr[p]);
        apb_read(REG_FANIN);
        apb_read(REG_ECN);
      end
      for (int n = 0; n < phase_items[p]; n++) begin
        random_packet(phase_keys[p], phase_noise[p]);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
